FILE: rtl/u8u16_pkg.sv
// Shared types, constants and lead-byte classification for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps

package u8u16_pkg;

  localparam int OUT_TDATA_W = 24;  // code_unit + error_length, padded to bytes

  // Lead byte ranges
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [3:0] LEAD3_HI    = 4'hE;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;

  // Second-byte limits after the special leads
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] E0_SEC_MIN  = 8'hA0;
  localparam logic [7:0] F0_SEC_MIN  = 8'h90;
  localparam logic [7:0] F4_SEC_MAX  = 8'h8F;
  localparam logic [1:0] CONT_TAG    = 2'b10;

  // Surrogate range and UTF-16 pair bases
  localparam logic [20:0] SURR_MIN   = 21'h00D800;
  localparam logic [20:0] SURR_MAX   = 21'h00DFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

  typedef enum logic [1:0] {
    KIND_UNIT      = 2'd0,
    KIND_MALFORMED = 2'd1,
    KIND_TRUNCATED = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] code_unit;
    logic [1:0]  error_length;
    logic        last_of_run;
  } res_t;

  // Result of looking at a byte as a new lead
  typedef struct packed {
    logic        has_res;
    res_t        res;
    logic        opens;
    logic [2:0]  seq_len;
    logic [20:0] accum;
  } lead_t;

  // Results handed from the decoder to the output queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t make_res(kind_t k, logic [15:0] u, logic [1:0] len);
    res_t r;
    r.kind         = k;
    r.code_unit    = u;
    r.error_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  function automatic lead_t take_lead(logic [7:0] b);
    lead_t l;
    l.has_res = 1'b0;
    l.res     = make_res(KIND_UNIT, 16'h0000, 2'd0);
    l.opens   = 1'b0;
    l.seq_len = 3'd0;
    l.accum   = 21'd0;
    if (b < ASCII_LIMIT) begin
      l.has_res = 1'b1;
      l.res     = make_res(KIND_UNIT, {8'h00, b}, 2'd0);
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      l.opens   = 1'b1;
      l.seq_len = 3'd2;
      l.accum   = {16'd0, b[4:0]};
    end else if (b[7:4] == LEAD3_HI) begin
      l.opens   = 1'b1;
      l.seq_len = 3'd3;
      l.accum   = {17'd0, b[3:0]};
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      l.opens   = 1'b1;
      l.seq_len = 3'd4;
      l.accum   = {18'd0, b[2:0]};
    end else begin
      l.has_res = 1'b1;
      l.res     = make_res(KIND_MALFORMED, 16'h0000, 2'd1);
    end
    return l;
  endfunction

endpackage

FILE: rtl/utf8_to_utf16_decoder.sv
// Top level of the validating UTF-8 to UTF-16 stream decoder.
`timescale 1ns / 1ps

// Validating UTF-8 to UTF-16 decoder. One UTF-8 byte enters per beat on the
// in_ stream (in_tlast marks the last byte of the stream); results leave on
// the out_ stream, one per beat, with out_tuser giving the kind: a UTF-16
// code unit, a malformed sequence, or a sequence cut off by the end of the
// stream. For errors out_tdata[17:16] carries the length in bytes of the bad
// sequence and the code unit field is zero. out_tlast marks the last result a
// byte produced; a byte that only opens or extends a sequence produces none.
// When a continuation position holds a bad byte, the error is reported and
// that byte is decoded again as a lead, so one byte can give two results, as
// does the final byte of a four-byte sequence (a surrogate pair).
// Timing: a byte sits in an input register, is decoded combinationally and
// its results land in a two-entry output queue whose head drives the port,
// so a result passes the input register and then a queue entry.
// The input takes one byte per cycle as long as results drain at the port's
// rate of one beat per cycle; a byte with two results stays in the input
// register while the queue cannot take both. While the receiver stalls, the
// queue absorbs two results before the input stops; once it is full, a byte
// with one result advances in the cycle out_tready pops, one with none at once.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,    // [7:0] data_byte
  input  logic                   in_tlast,    // final_byte

  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [15:0] code_unit, [17:16] error_length
  output logic [1:0]             out_tuser,   // kind
  output logic                   out_tlast    // last_of_run
);

  // input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_final_r;

  logic       advance;
  logic [1:0] free_slots;
  push_t      push;

  // the register frees up whenever its byte moves on this cycle
  assign in_tready    = !in_valid_r || advance;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n)
      in_valid_r <= 1'b0;
    else
      in_valid_r <= in_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_final_r <= in_tlast;
    end
  end

  u8u16_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_valid_r),
    .byte_data  (in_byte_r),
    .byte_final (in_final_r),
    .free_slots (free_slots),
    .advance    (advance),
    .push       (push)
  );

  u8u16_oq u_oq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .free_slots (free_slots),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/u8u16_dec.sv
// Sequence state and per-byte decode: turns the registered byte into zero to two results.
`timescale 1ns / 1ps

module u8u16_dec
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_data,
  input  logic       byte_final,
  input  logic [1:0] free_slots,
  output logic       advance,
  output push_t      push
);

  logic [7:0]  lead_byte_r,  lead_byte_nxt;
  logic [20:0] code_accum_r, code_accum_nxt;
  logic [1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [2:0]  seq_length_r, seq_length_nxt;

  lead_t       lead;
  logic        cont;
  logic        bad2;
  logic        redo;
  logic [20:0] acc_step;
  logic [19:0] supp;
  logic [1:0]  n;
  res_t        res [2];

  always_comb begin
    lead     = take_lead(byte_data);
    cont     = (byte_data[7:6] == CONT_TAG);
    acc_step = {code_accum_r[14:0], byte_data[5:0]};
    supp     = 20'(acc_step - SUPP_BASE);
    bad2     = !cont ||
               (seq_length_r == 3'd3 && lead_byte_r == LEAD_E0 && byte_data < E0_SEC_MIN) ||
               (seq_length_r == 3'd4 && lead_byte_r == LEAD_F0 && byte_data < F0_SEC_MIN) ||
               (seq_length_r == 3'd4 && lead_byte_r == LEAD_F4 && byte_data > F4_SEC_MAX);

    lead_byte_nxt  = lead_byte_r;
    code_accum_nxt = code_accum_r;
    bytes_seen_nxt = bytes_seen_r;
    seq_length_nxt = seq_length_r;
    redo           = 1'b0;
    n              = 2'd0;
    res[0]         = make_res(KIND_UNIT, 16'h0000, 2'd0);
    res[1]         = make_res(KIND_UNIT, 16'h0000, 2'd0);

    case (bytes_seen_r)
      2'd0: begin
        redo = 1'b1;
      end
      2'd1: begin
        if (bad2) begin
          res[0] = make_res(KIND_MALFORMED, 16'h0000, 2'd1);
          n      = 2'd1;
          redo   = 1'b1;
          bytes_seen_nxt = 2'd0;
        end else begin
          code_accum_nxt = acc_step;
          bytes_seen_nxt = 2'd2;
          if (seq_length_r == 3'd2) begin
            res[0] = make_res(KIND_UNIT, acc_step[15:0], 2'd0);
            n      = 2'd1;
            bytes_seen_nxt = 2'd0;
          end
        end
      end
      2'd2: begin
        if (!cont) begin
          res[0] = make_res(KIND_MALFORMED, 16'h0000, 2'd2);
          n      = 2'd1;
          redo   = 1'b1;
          bytes_seen_nxt = 2'd0;
        end else begin
          code_accum_nxt = acc_step;
          bytes_seen_nxt = 2'd3;
          if (seq_length_r == 3'd3) begin
            if (acc_step >= SURR_MIN && acc_step <= SURR_MAX)
              res[0] = make_res(KIND_MALFORMED, 16'h0000, 2'd3);
            else
              res[0] = make_res(KIND_UNIT, acc_step[15:0], 2'd0);
            n = 2'd1;
            bytes_seen_nxt = 2'd0;
          end
        end
      end
      default: begin
        if (!cont) begin
          res[0] = make_res(KIND_MALFORMED, 16'h0000, 2'd3);
          n      = 2'd1;
          redo   = 1'b1;
        end else begin
          res[0] = make_res(KIND_UNIT, {HI_SURR_TAG, supp[19:10]}, 2'd0);
          res[1] = make_res(KIND_UNIT, {LO_SURR_TAG, supp[9:0]}, 2'd0);
          n      = 2'd2;
        end
        bytes_seen_nxt = 2'd0;
      end
    endcase

    // sequence closed: clear the gathered context
    if (bytes_seen_nxt == 2'd0) begin
      lead_byte_nxt  = 8'h00;
      code_accum_nxt = 21'd0;
      seq_length_nxt = 3'd0;
    end

    // byte taken again as a lead
    if (redo) begin
      if (lead.has_res) begin
        res[n[0]] = lead.res;
        n = n + 2'd1;
      end
      if (lead.opens) begin
        lead_byte_nxt  = byte_data;
        code_accum_nxt = lead.accum;
        bytes_seen_nxt = 2'd1;
        seq_length_nxt = lead.seq_len;
      end
    end

    // end of stream with a sequence open
    if (byte_final && bytes_seen_nxt != 2'd0) begin
      res[n[0]] = make_res(KIND_TRUNCATED, 16'h0000, bytes_seen_nxt);
      n = n + 2'd1;
      lead_byte_nxt  = 8'h00;
      code_accum_nxt = 21'd0;
      bytes_seen_nxt = 2'd0;
      seq_length_nxt = 3'd0;
    end

    if (n != 2'd0)
      res[n[1]].last_of_run = 1'b1;

    advance = byte_valid && (n <= free_slots);
    push.n  = advance ? n : 2'd0;
    push.r0 = res[0];
    push.r1 = res[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_byte_r  <= 8'h00;
      code_accum_r <= 21'd0;
      bytes_seen_r <= 2'd0;
      seq_length_r <= 3'd0;
    end else if (advance) begin
      lead_byte_r  <= lead_byte_nxt;
      code_accum_r <= code_accum_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      seq_length_r <= seq_length_nxt;
    end
  end

endmodule

FILE: rtl/u8u16_oq.sv
// Two-entry result queue that drives the result stream.
`timescale 1ns / 1ps

module u8u16_oq
  import u8u16_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  push_t                  push,
  output logic [1:0]             free_slots,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [15:0] code_unit, [17:16] error_length
  output logic [1:0]             out_tuser,   // kind
  output logic                   out_tlast    // last_of_run
);

  res_t       q0_r, q0_nxt;
  res_t       q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_left;
  logic       pop;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign cnt_left   = cnt_r - {1'b0, pop};
  assign free_slots = 2'd2 - cnt_left;

  assign out_tdata  = {{(OUT_TDATA_W - 18){1'b0}}, q0_r.error_length, q0_r.code_unit};
  assign out_tuser  = q0_r.kind;
  assign out_tlast  = q0_r.last_of_run;

  always_comb begin
    q0_nxt  = pop ? q1_r : q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_left + push.n;
    if (push.n != 2'd0) begin
      if (cnt_left == 2'd0) begin
        q0_nxt = push.r0;
        q1_nxt = push.r1;
      end else begin
        q1_nxt = push.r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      cnt_r <= 2'd0;
    else
      cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

FILE: rtl/u8u16_chk.sv
// Port-level checker for the decoder, bound to the top level.
`timescale 1ns / 1ps

module u8u16_chk
  import u8u16_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]             out_tuser,
  input logic                   out_tlast
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_UNIT || out_tuser == KIND_MALFORMED ||
                    out_tuser == KIND_TRUNCATED))
    else $error("illegal result kind");

  a_unit_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_UNIT |-> out_tdata[17:16] == 2'd0)
    else $error("code unit with nonzero error length");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_UNIT |->
      out_tdata[15:0] == 16'h0000 && out_tdata[17:16] != 2'd0)
    else $error("error beat with bad fields");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_TRUNCATED |-> out_tlast)
    else $error("truncation not last of its run");

endmodule

bind utf8_to_utf16_decoder u8u16_chk u_chk (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
`timescale 1ns / 1ps

module tb_top;
  import u8u16_pkg::*;

  localparam int STALL_LIMIT = 4000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  utf8_to_utf16_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Decoder mirror state
  logic [7:0]  open_lead = 8'h00;
  logic [20:0] cp_bits = 21'd0;
  logic [1:0]  taken = 2'd0;    // bytes of the open sequence, 0 = none open
  logic [2:0]  want_len = 3'd0;

  res_t utf16_due[$];   // results still owed by the block, oldest first
  res_t byte_run[$];    // results of the byte being decoded

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;    // hold-offs asked for by the tests
  int hold_done = 0;    // hold-offs started by the receiver
  int hold_left = 0;
  int bytes_sent = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int malformed_seen = 0;
  int truncated_seen = 0;
  int surrogate_pairs = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  logic [7:0] seq_bytes[$];  // stimulus under construction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void emit(kind_t k, logic [15:0] unit, logic [1:0] len);
    res_t r;
    r.kind         = k;
    r.code_unit    = unit;
    r.error_length = len;
    r.last_of_run  = 1'b0;
    byte_run.push_back(r);
  endfunction

  function automatic void close_open();
    open_lead = 8'h00;
    cp_bits   = 21'd0;
    taken     = 2'd0;
    want_len  = 3'd0;
  endfunction

  function automatic void start_seq(logic [7:0] b, logic [2:0] n, logic [20:0] bits);
    open_lead = b;
    cp_bits   = bits;
    taken     = 2'd1;
    want_len  = n;
  endfunction

  // Byte seen with no sequence open
  function automatic void lead_as(logic [7:0] b);
    if (b < 8'h80) begin
      emit(KIND_UNIT, {8'h00, b}, 2'd0);
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      start_seq(b, 3'd2, {16'd0, b[4:0]});
    end else if (b[7:4] == 4'hE) begin
      start_seq(b, 3'd3, {17'd0, b[3:0]});
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      start_seq(b, 3'd4, {18'd0, b[2:0]});
    end else begin
      emit(KIND_MALFORMED, 16'h0000, 2'd1);
    end
  endfunction

  function automatic void gather(logic [7:0] b);
    cp_bits = {cp_bits[14:0], b[5:0]};
    taken   = taken + 2'd1;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic        cont;
    logic        bad;
    logic [20:0] off;
    cont = (b[7:6] == 2'b10);
    byte_run.delete();
    case (taken)
      2'd0: begin
        lead_as(b);
      end
      2'd1: begin
        bad = !cont ||
              (want_len == 3'd3 && open_lead == 8'hE0 && b < 8'hA0) ||
              (want_len == 3'd4 && open_lead == 8'hF0 && b < 8'h90) ||
              (want_len == 3'd4 && open_lead == 8'hF4 && b > 8'h8F);
        if (bad) begin
          // error covers the lead only; this byte starts over as a lead
          close_open();
          emit(KIND_MALFORMED, 16'h0000, 2'd1);
          lead_as(b);
        end else begin
          gather(b);
          if (want_len == 3'd2) begin
            emit(KIND_UNIT, cp_bits[15:0], 2'd0);
            close_open();
          end
        end
      end
      2'd2: begin
        if (!cont) begin
          close_open();
          emit(KIND_MALFORMED, 16'h0000, 2'd2);
          lead_as(b);
        end else begin
          gather(b);
          if (want_len == 3'd3) begin
            // encoded surrogate is rejected as a whole, nothing re-read
            if (cp_bits >= 21'h00D800 && cp_bits <= 21'h00DFFF)
              emit(KIND_MALFORMED, 16'h0000, 2'd3);
            else
              emit(KIND_UNIT, cp_bits[15:0], 2'd0);
            close_open();
          end
        end
      end
      default: begin
        if (!cont) begin
          close_open();
          emit(KIND_MALFORMED, 16'h0000, 2'd3);
          lead_as(b);
        end else begin
          // four-byte sequence ends in a surrogate pair
          cp_bits = {cp_bits[14:0], b[5:0]};
          off = cp_bits - 21'h010000;
          emit(KIND_UNIT, {6'b110110, off[19:10]}, 2'd0);
          emit(KIND_UNIT, {6'b110111, off[9:0]}, 2'd0);
          close_open();
        end
      end
    endcase
    if (fin && taken != 2'd0) begin
      emit(KIND_TRUNCATED, 16'h0000, taken);
      close_open();
    end
    if (byte_run.size() > 0)
      byte_run[byte_run.size()-1].last_of_run = 1'b1;
    foreach (byte_run[i])
      utf16_due.push_back(byte_run[i]);
  endfunction

  // Every input beat feeds the mirror
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      decode_byte(in_tdata, in_tlast);
      bytes_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  res_t due_head;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser == KIND_MALFORMED) malformed_seen++;
      if (out_tuser == KIND_TRUNCATED) truncated_seen++;
      if (out_tuser == KIND_UNIT && out_tdata[15:10] == 6'b110111) surrogate_pairs++;
      if (utf16_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat: expected none, got kind=%0d unit=%h len=%0d last=%0b",
                 $time, out_tuser, out_tdata[15:0], out_tdata[17:16], out_tlast);
      end else begin
        due_head = utf16_due.pop_front();
        if (out_tuser != due_head.kind || out_tdata[15:0] != due_head.code_unit ||
            out_tdata[17:16] != due_head.error_length ||
            out_tlast != due_head.last_of_run) begin
          mismatches++;
          $display("%0t: result mismatch: expected kind=%0d unit=%h len=%0d last=%0b, %s",
                   $time, due_head.kind, due_head.code_unit, due_head.error_length,
                   due_head.last_of_run,
                   $sformatf("got kind=%0d unit=%h len=%0d last=%0b", out_tuser,
                             out_tdata[15:0], out_tdata[17:16], out_tlast));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done  = hold_reqs;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any beat on either side resets the count
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, utf16_due.size());
      $display("utf8_to_utf16_decoder regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // One input beat; random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // Stop offering and wait until every owed result has left
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (utf16_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_seq(input logic fin_last);
    foreach (seq_bytes[i])
      send_byte(seq_bytes[i], (i == seq_bytes.size() - 1) && fin_last);
  endtask

  // Range ends come up often
  function automatic logic [20:0] pick_in(int lo, int hi);
    case ($urandom_range(7))
      0:       return 21'(lo);
      1:       return 21'(hi);
      default: return 21'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic void encode_cp(logic [20:0] cp, int n);
    seq_bytes.delete();
    case (n)
      1: seq_bytes.push_back(cp[7:0]);
      2: begin
        seq_bytes.push_back({3'b110, cp[10:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        seq_bytes.push_back({4'b1110, cp[15:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        seq_bytes.push_back({5'b11110, cp[20:18]});
        seq_bytes.push_back({2'b10, cp[17:12]});
        seq_bytes.push_back({2'b10, cp[11:6]});
        seq_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // A character of random length, well-formed but for an encoded surrogate now and then
  function automatic void make_char(output int n);
    logic [20:0] cp;
    n = $urandom_range(1, 4);
    case (n)
      1: cp = pick_in('h0, 'h7F);
      2: cp = pick_in('h80, 'h7FF);
      3: begin
        if ($urandom_range(9) == 0) begin
          cp = pick_in('hD800, 'hDFFF);
        end else begin
          do cp = pick_in('h800, 'hFFFF); while (cp >= 'hD800 && cp <= 'hDFFF);
        end
      end
      default: cp = pick_in('h10000, 'h10FFFF);
    endcase
    encode_cp(cp, n);
  endfunction

  // Mostly valid text, some cut or odd sequences, some raw noise
  task automatic send_text(input int n_bytes);
    int stop_at;
    int mode;
    int n;
    int keep;
    logic [7:0] lead;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        make_char(n);
      end else if (mode < 82) begin
        // valid start cut short, then any byte
        do make_char(n); while (n < 2);
        keep = $urandom_range(1, n - 1);
        while (seq_bytes.size() > keep) void'(seq_bytes.pop_back());
        seq_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (mode < 92) begin
        // leads with a limited second byte, or ED for the surrogate range, any continuation after
        case ($urandom_range(3))
          0:       lead = 8'hE0;
          1:       lead = 8'hED;
          2:       lead = 8'hF0;
          default: lead = 8'hF4;
        endcase
        seq_bytes.delete();
        seq_bytes.push_back(lead);
        repeat ((lead[4] ? 3 : 2)) seq_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else begin
        seq_bytes.delete();
        seq_bytes.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq_bytes[i])
        send_byte(seq_bytes[i], $urandom_range(99) < 3);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);                    // end of stream, nothing open
    encode_cp('h80, 2);     send_seq(1'b0);
    encode_cp('h7FF, 2);    send_seq(1'b0);
    encode_cp('h800, 3);    send_seq(1'b0);
    encode_cp('hD800, 3);   send_seq(1'b0);    // encoded surrogate
    encode_cp('h10FFFF, 4); send_seq(1'b0);    // top of range, surrogate pair
    send_byte(8'hFF, 1'b0);                    // bad lead
    send_byte(8'hE0, 1'b0);                    // second byte under the E0 limit
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b0);                    // second byte under the F0 limit
    send_byte(8'h8F, 1'b0);
    send_byte(8'hF1, 1'b0);                    // third byte not a continuation
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hF1, 1'b0);                    // fourth byte opens a new lead on end
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC3, 1'b1);
    wait_drained();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_text(200); wait_drained();
    send_idle_pct = 80; recv_stall_pct = 0;  send_text(200); wait_drained();
    send_idle_pct = 0;  recv_stall_pct = 80; send_text(200); wait_drained();
    send_idle_pct = 34; recv_stall_pct = 34; send_text(200); wait_drained();
  endtask

  // Receiver holds off while bytes keep coming, so the block backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    send_text(80);
    wait_drained();
  endtask

  // Sender goes quiet until every owed result is out, several times
  task automatic test_sender_pause();
    send_idle_pct  = 10;
    recv_stall_pct = 20;
    repeat (4) begin
      send_text(15);
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    test_backpressure();
    test_sender_pause();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("%0d bytes decoded into %0d results: %0d malformed, %0d truncated, %0d pairs",
             bytes_taken, results_seen, malformed_seen, truncated_seen, surrogate_pairs);
    $display("idle and stall mixes, a %0d-cycle output hold-off and drained pauses ran",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("utf8_to_utf16_decoder regression: pass");
    end else begin
      $display("%0d result beats were wrong", mismatches);
      $display("utf8_to_utf16_decoder regression: fail");
    end
    $finish;
  end

endmodule
